// File: sv/lie_pkg.sv
package lie_pkg;

   // fixed field widths
   localparam int DATA_W   = 32;
   localparam int DEGREE_W = 4;
   localparam int WIDE_W   = 64;

   // clamp bound for products and partial sums: 2^62 - 1
   localparam logic signed [WIDE_W-1:0] WIDE_CAP = 64'sh3FFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUP_RK,
      ST_DUP_LK,
      ST_DUP_RJ,
      ST_DUP_CMP,
      ST_DUP_END,
      ST_EV_RI,
      ST_EV_LI,
      ST_EV_JCHK,
      ST_EV_LJ,
      ST_EV_DIV,
      ST_EV_MUL,
      ST_TERM_W,
      ST_EMIT,
      ST_CLR
   } state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } alu_rsp_type;

endpackage

// File: sv/lagrange_interpolation_eval.sv
// Lagrange interpolation evaluator. Nodes (x, y) in signed fixed point load one per
// cycle into an on-chip store of MAX_POINTS entries; extra nodes are dropped and
// flagged. The node marked last starts evaluation at query x for every degree k
// from 1 to n-1, one result per degree in ascending order, and the block takes no
// node until the run is over. All multiplies and divides go through one bit-serial
// unit. Each factor costs one divide, one multiply and two sequencing steps; each
// result may wait on the result channel, and a final step clears the store at the
// end of the run. A degree whose nodes share an x value skips the arithmetic and
// returns zero with divide_error set.
module lagrange_interpolation_eval #(
   parameter int MAX_POINTS = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [lie_pkg::DATA_W-1:0]   req_node_x,
   input  logic signed [lie_pkg::DATA_W-1:0]   req_node_y,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lie_pkg::DEGREE_W-1:0]        rsp_degree,
   output logic signed [lie_pkg::DATA_W-1:0]   rsp_interp_value,
   output logic                                rsp_divide_error,
   output logic                                rsp_overflow_flag,
   output logic                                rsp_last_result,
   input  logic                                csr_wr_en,
   input  logic signed [lie_pkg::DATA_W-1:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int DW    = lie_pkg::DATA_W;
   localparam int W     = lie_pkg::WIDE_W;

   lie_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic signed [DW-1:0]    query_ff;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic signed [DW-1:0]    xi_ff, xi_in;
   logic signed [DW-1:0]    yi_ff, yi_in;
   logic signed [W-1:0]     p_ff, p_in;
   logic signed [W-1:0]     sum_ff, sum_in;
   logic                    sat_ff, sat_in;
   logic                    dup_ff, dup_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [lie_pkg::DEGREE_W-1:0] rsp_degree_ff, rsp_degree_in;
   logic signed [DW-1:0]    rsp_value_ff, rsp_value_in;
   logic                    rsp_dup_ff, rsp_dup_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [2*DW-1:0]         rd_data;
   logic signed [DW-1:0]    rd_x, rd_y;
   logic [CNT_W-1:0]        n_new;

   lie_pkg::alu_req_type    alu_req;
   lie_pkg::alu_rsp_type    alu_rsp;
   logic signed [W-1:0]     alu_a, alu_b, alu_res;

   logic signed [W:0]       acc_sum;
   logic signed [W-1:0]     acc_clamp;
   logic                    acc_sat;
   logic signed [DW-1:0]    val32;
   logic                    val_sat;
   logic                    slot_free;

   // node store
   lie_ram #(
      .WIDTH (2 * DW),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_node_x, req_node_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[2*DW-1:DW];
   assign rd_y = rd_data[DW-1:0];

   // shared arithmetic unit
   lie_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .rsp    (alu_rsp),
      .result (alu_res)
   );

   assign req_ready = (state_ff == lie_pkg::ST_IDLE);
   assign wr_en     = req_valid && req_ready && (count_ff < CNT_W'(MAX_POINTS));
   assign n_new     = wr_en ? count_ff + CNT_W'(1) : count_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // running sum with clamp
   assign acc_sum = W'(sum_ff) + W'(alu_res);
   always_comb begin
      acc_sat   = 1'b0;
      acc_clamp = acc_sum[W-1:0];
      if (acc_sum > (W+1)'(lie_pkg::WIDE_CAP)) begin
         acc_clamp = lie_pkg::WIDE_CAP;
         acc_sat   = 1'b1;
      end else if (acc_sum < -(W+1)'(lie_pkg::WIDE_CAP)) begin
         acc_clamp = -lie_pkg::WIDE_CAP;
         acc_sat   = 1'b1;
      end
   end

   // final clamp to 32 bits
   always_comb begin
      val_sat = 1'b0;
      val32   = sum_ff[DW-1:0];
      if (sum_ff > W'(64'sd2147483647)) begin
         val32   = 32'sh7FFF_FFFF;
         val_sat = 1'b1;
      end else if (sum_ff < -W'(64'sd2147483648)) begin
         val32   = 32'sh8000_0000;
         val_sat = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      xi_in         = xi_ff;
      yi_in         = yi_ff;
      p_in          = p_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      dup_in        = dup_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_degree_in = rsp_degree_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_dup_in    = rsp_dup_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = j_ff[IDX_W-1:0];
      alu_req.start = 1'b0;
      alu_req.op    = lie_pkg::OP_MUL;
      alu_a         = p_ff;
      alu_b         = alu_res;
      unique case (state_ff)
         lie_pkg::ST_IDLE: begin
            if (req_valid) begin
               count_in = n_new;
               if (!wr_en) begin
                  dropped_in = 1'b1;
               end
               if (req_last_point) begin
                  k_in   = CNT_W'(1);
                  dup_in = 1'b0;
                  state_in = (n_new >= CNT_W'(2)) ? lie_pkg::ST_DUP_RK : lie_pkg::ST_CLR;
               end
            end
         end
         lie_pkg::ST_DUP_RK: begin
            rd_addr  = k_ff[IDX_W-1:0];
            sat_in   = 1'b0;
            state_in = lie_pkg::ST_DUP_LK;
         end
         lie_pkg::ST_DUP_LK: begin
            xi_in    = rd_x;
            j_in     = '0;
            state_in = lie_pkg::ST_DUP_RJ;
         end
         lie_pkg::ST_DUP_RJ: begin
            state_in = lie_pkg::ST_DUP_CMP;
         end
         lie_pkg::ST_DUP_CMP: begin
            if (rd_x == xi_ff) begin
               dup_in = 1'b1;
            end
            j_in     = j_ff + CNT_W'(1);
            state_in = (j_ff + CNT_W'(1) == k_ff) ? lie_pkg::ST_DUP_END : lie_pkg::ST_DUP_RJ;
         end
         lie_pkg::ST_DUP_END: begin
            sum_in   = '0;
            i_in     = '0;
            state_in = dup_ff ? lie_pkg::ST_EMIT : lie_pkg::ST_EV_RI;
         end
         lie_pkg::ST_EV_RI: begin
            rd_addr  = i_ff[IDX_W-1:0];
            state_in = lie_pkg::ST_EV_LI;
         end
         lie_pkg::ST_EV_LI: begin
            xi_in    = rd_x;
            yi_in    = rd_y;
            p_in     = W'(1) << FRAC_BITS;
            j_in     = '0;
            state_in = lie_pkg::ST_EV_JCHK;
         end
         lie_pkg::ST_EV_JCHK: begin
            if (j_ff > k_ff) begin
               // term for node i: product times y_i
               alu_req.start = 1'b1;
               alu_b         = W'(yi_ff);
               state_in      = lie_pkg::ST_TERM_W;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               state_in = lie_pkg::ST_EV_LJ;
            end
         end
         lie_pkg::ST_EV_LJ: begin
            // factor (q - x_j) / (x_i - x_j)
            alu_req.start = 1'b1;
            alu_req.op    = lie_pkg::OP_DIV;
            alu_a         = W'(query_ff) - W'(rd_x);
            alu_b         = W'(xi_ff) - W'(rd_x);
            state_in      = lie_pkg::ST_EV_DIV;
         end
         lie_pkg::ST_EV_DIV: begin
            if (alu_rsp.done) begin
               alu_req.start = 1'b1;
               state_in      = lie_pkg::ST_EV_MUL;
            end
         end
         lie_pkg::ST_EV_MUL: begin
            if (alu_rsp.done) begin
               p_in     = alu_res;
               sat_in   = sat_ff || alu_rsp.sat;
               j_in     = j_ff + CNT_W'(1);
               state_in = lie_pkg::ST_EV_JCHK;
            end
         end
         lie_pkg::ST_TERM_W: begin
            if (alu_rsp.done) begin
               sum_in   = acc_clamp;
               sat_in   = sat_ff || alu_rsp.sat || acc_sat;
               i_in     = i_ff + CNT_W'(1);
               state_in = (i_ff == k_ff) ? lie_pkg::ST_EMIT : lie_pkg::ST_EV_RI;
            end
         end
         lie_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_degree_in = lie_pkg::DEGREE_W'(k_ff);
               rsp_value_in  = dup_ff ? '0 : val32;
               rsp_dup_in    = dup_ff;
               rsp_ovf_in    = dropped_ff || (!dup_ff && (sat_ff || val_sat));
               rsp_last_in   = (k_ff + CNT_W'(1) == count_ff);
               k_in          = k_ff + CNT_W'(1);
               state_in      = (k_ff + CNT_W'(1) == count_ff) ?
                               lie_pkg::ST_CLR : lie_pkg::ST_DUP_RK;
            end
         end
         lie_pkg::ST_CLR: begin
            count_in   = '0;
            dropped_in = 1'b0;
            state_in   = lie_pkg::ST_IDLE;
         end
         default: begin
            state_in = lie_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lie_pkg::ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         query_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            query_ff <= csr_wr_data;
         end
      end
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      xi_ff         <= xi_in;
      yi_ff         <= yi_in;
      p_ff          <= p_in;
      sum_ff        <= sum_in;
      sat_ff        <= sat_in;
      dup_ff        <= dup_in;
      rsp_degree_ff <= rsp_degree_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_dup_ff    <= rsp_dup_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_degree        = rsp_degree_ff;
   assign rsp_interp_value  = rsp_value_ff;
   assign rsp_divide_error  = rsp_dup_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;
   assign rsp_last_result   = rsp_last_ff;

endmodule

// File: sv/lie_ram.sv
module lie_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lie_alu.sv
module lie_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lie_pkg::alu_req_type                   req,
   input  logic signed [lie_pkg::WIDE_W-1:0]      op_a,
   input  logic signed [lie_pkg::WIDE_W-1:0]      op_b,
   output lie_pkg::alu_rsp_type                   rsp,
   output logic signed [lie_pkg::WIDE_W-1:0]      result
);

   localparam int W = lie_pkg::WIDE_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [6:0]           cnt_ff, cnt_in;
   lie_pkg::alu_op_type  op_ff, op_in;
   logic                 neg_ff, neg_in;
   logic [W-1:0]         ma_ff, ma_in;
   logic [W-1:0]         mb_ff, mb_in;
   logic [2*W-1:0]       acc_ff, acc_in;

   logic [W-1:0]         mag_a, mag_b;
   logic [W:0]           add_sum;
   logic [W:0]           trial;
   logic [W:0]           diff;
   logic [W-1:0]         mag_r;
   logic                 mul_sat;

   assign mag_a = op_a[W-1] ? (W'(0) - W'(op_a)) : W'(op_a);
   assign mag_b = op_b[W-1] ? (W'(0) - W'(op_b)) : W'(op_b);

   // one bit per cycle: shift-add multiply or restoring divide
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      add_sum = {1'b0, acc_ff[2*W-1:W]} + (mb_ff[0] ? {1'b0, ma_ff} : (W+1)'(0));
      trial   = {acc_ff[2*W-1:W], acc_ff[W-1]};
      diff    = trial - {1'b0, mb_ff};
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = req.op;
         neg_in  = op_a[W-1] ^ op_b[W-1];
         if (req.op == lie_pkg::OP_DIV) begin
            ma_in  = '0;
            mb_in  = mag_b;
            acc_in = {W'(0), mag_a << FRAC_BITS};
         end else begin
            ma_in  = mag_a;
            mb_in  = mag_b;
            acc_in = '0;
         end
      end else if (busy_ff) begin
         if (op_ff == lie_pkg::OP_DIV) begin
            if (!diff[W]) begin
               acc_in = {diff[W-1:0], acc_ff[W-2:0], 1'b1};
            end else begin
               acc_in = {trial[W-1:0], acc_ff[W-2:0], 1'b0};
            end
         end else begin
            acc_in = {add_sum, acc_ff[W-1:1]};
            mb_in  = mb_ff >> 1;
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
   end

   // result: product scaled down and clamped, or quotient
   assign mul_sat = |acc_ff[2*W-1:FRAC_BITS+62];
   always_comb begin
      if (op_ff == lie_pkg::OP_DIV) begin
         mag_r = acc_ff[W-1:0];
      end else if (mul_sat) begin
         mag_r = W'(lie_pkg::WIDE_CAP);
      end else begin
         mag_r = {2'b00, acc_ff[FRAC_BITS+61:FRAC_BITS]};
      end
   end

   assign result   = neg_ff ? -$signed(mag_r) : $signed(mag_r);
   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.sat  = (op_ff == lie_pkg::OP_MUL) && mul_sat;

endmodule

// File: sv/lie_checker.sv
module lie_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_degree,
   input logic [31:0] rsp_interp_value,
   input logic        rsp_divide_error,
   input logic        rsp_last_result
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interp_value))
      else $error("result changed while stalled");

   // a divide error result carries zero
   a_dup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_interp_value == 32'd0)
      else $error("divide error with nonzero value");

   // degrees start at one
   a_degree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_degree != 4'd0)
      else $error("degree zero result");

   // the run goes on after a result that is not the last
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_result |=> !req_ready)
      else $error("input taken in the middle of a run");

endmodule

bind lagrange_interpolation_eval lie_checker u_lie_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_degree       (rsp_degree),
   .rsp_interp_value (rsp_interp_value),
   .rsp_divide_error (rsp_divide_error),
   .rsp_last_result  (rsp_last_result)
);

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int NODE_CAP   = 8;
   localparam int FRAC       = 16;
   localparam int CYCLE_CAP  = 4000000;
   localparam int HOLD_LEN   = 3000;
   localparam logic [63:0] PROD_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [lie_pkg::DATA_W-1:0] x;
      logic signed [lie_pkg::DATA_W-1:0] y;
      logic                              last;
   } node_item_type;

   typedef struct packed {
      logic [lie_pkg::DEGREE_W-1:0]      degree;
      logic signed [lie_pkg::DATA_W-1:0] value;
      logic                              div_err;
      logic                              ovf;
      logic                              last;
   } interp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [lie_pkg::DATA_W-1:0] req_node_x = '0;
   logic signed [lie_pkg::DATA_W-1:0] req_node_y = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [lie_pkg::DEGREE_W-1:0] rsp_degree;
   logic signed [lie_pkg::DATA_W-1:0] rsp_interp_value;
   logic rsp_divide_error, rsp_overflow_flag, rsp_last_result;
   logic csr_wr_en = 1'b0;
   logic signed [lie_pkg::DATA_W-1:0] csr_wr_data = '0;

   node_item_type     node_queue[$];
   interp_result_type result_queue[$];
   int                err_count = 0;
   int                cycle_count = 0;
   bit                stim_done = 0;

   // predictor state
   logic signed [63:0] px[NODE_CAP];
   logic signed [63:0] py[NODE_CAP];
   int                 pcount = 0;
   bit                 pdrop = 0;
   logic signed [63:0] pquery = 0;
   bit                 psat;

   lagrange_interpolation_eval u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_node_x(req_node_x), .req_node_y(req_node_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_degree(rsp_degree), .rsp_interp_value(rsp_interp_value),
      .rsp_divide_error(rsp_divide_error), .rsp_overflow_flag(rsp_overflow_flag),
      .rsp_last_result(rsp_last_result),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // fixed-point multiply on magnitudes, truncated, clamped
   function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [63:0]  ua, ub;
      logic [127:0] prod;
      logic [63:0]  r;
      bit           neg;
      ua   = a[63] ? -a : a;
      ub   = b[63] ? -b : b;
      neg  = a[63] ^ b[63];
      prod = {64'b0, ua} * {64'b0, ub};
      prod = prod >> FRAC;
      if (prod > {64'b0, PROD_CAP}) begin
         r    = PROD_CAP;
         psat = 1;
      end else begin
         r = prod[63:0];
      end
      return neg ? -$signed(r) : $signed(r);
   endfunction

   // factor division on magnitudes, truncated
   function automatic logic signed [63:0] fix_div(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
      logic [63:0] un, ud, q;
      un = (num[63] ? -num : num) << FRAC;
      ud = den[63] ? -den : den;
      q  = un / ud;
      return (num[63] ^ den[63]) ? -$signed(q) : $signed(q);
   endfunction

   // absorb one node; on last, queue one expected result per degree
   task automatic predict_node(input node_item_type it);
      interp_result_type er;
      logic signed [63:0] sum, p, s;
      bit dup;
      if (pcount < NODE_CAP) begin
         px[pcount] = it.x;
         py[pcount] = it.y;
         pcount++;
      end else begin
         pdrop = 1;
      end
      if (!it.last) return;
      for (int k = 1; k < pcount; k++) begin
         dup  = 0;
         psat = 0;
         sum  = 0;
         for (int i = 0; i <= k; i++)
            for (int j = i + 1; j <= k; j++)
               if (px[i] == px[j]) dup = 1;
         if (!dup) begin
            for (int i = 0; i <= k; i++) begin
               p = 64'sd1 << FRAC;
               for (int j = 0; j <= k; j++)
                  if (j != i) p = fix_mul(p, fix_div(pquery - px[j], px[i] - px[j]));
               s = sum + fix_mul(p, py[i]);
               if (s > $signed(PROD_CAP)) begin
                  s = PROD_CAP; psat = 1;
               end
               if (s < -$signed(PROD_CAP)) begin
                  s = -$signed(PROD_CAP); psat = 1;
               end
               sum = s;
            end
            if (sum > 64'sd2147483647) begin
               sum = 64'sd2147483647; psat = 1;
            end
            if (sum < -64'sd2147483648) begin
               sum = -64'sd2147483648; psat = 1;
            end
         end else begin
            sum  = 0;
            psat = 0;
         end
         er.degree  = k[lie_pkg::DEGREE_W-1:0];
         er.value   = sum[lie_pkg::DATA_W-1:0];
         er.div_err = dup;
         er.ovf     = psat | pdrop;
         er.last    = (k == pcount - 1);
         result_queue.push_back(er);
      end
      pcount = 0;
      pdrop  = 0;
   endtask

   // driver: bursts and gaps, one nonblocking write per signal per edge
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      node_item_type nxt;
      bit            load;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_node({req_node_x, req_node_y, req_last_point});
         if (!req_valid || req_ready) begin
            load = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (node_queue.size() > 0) begin
               nxt  = node_queue.pop_front();
               load = 1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= load;
            if (load) begin
               req_node_x     <= nxt.x;
               req_node_y     <= nxt.y;
               req_last_point <= nxt.last;
            end
         end
      end
   end

   // long receiver hold-off once a result waits while the sender offers a node
   int  hold_cnt = 0;
   bit  hold_off = 0;
   bit  hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         hold_off <= 1'b0;
      end else if (hold_off) begin
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt >= HOLD_LEN) begin
            hold_off  <= 1'b0;
            hold_done <= 1'b1;
         end
      end else if (!hold_done && rsp_valid && req_valid && !req_ready) begin
         hold_cnt <= 0;
         hold_off <= 1'b1;
      end
   end

   // monitor: stall pattern and compare
   always @(posedge clock) begin
      interp_result_type er;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_queue.size() == 0) begin
               $error("unexpected result transfer degree=%0d", rsp_degree);
               err_count++;
            end else begin
               er = result_queue.pop_front();
               if (rsp_degree !== er.degree) begin
                  $error("degree: expected %0d actual %0d", er.degree, rsp_degree);
                  err_count++;
               end
               if (rsp_interp_value !== er.value) begin
                  $error("interp_value: expected %0d actual %0d", er.value,
                         rsp_interp_value);
                  err_count++;
               end
               if (rsp_divide_error !== er.div_err) begin
                  $error("divide_error: expected %0d actual %0d", er.div_err,
                         rsp_divide_error);
                  err_count++;
               end
               if (rsp_overflow_flag !== er.ovf) begin
                  $error("overflow_flag: expected %0d actual %0d", er.ovf,
                         rsp_overflow_flag);
                  err_count++;
               end
               if (rsp_last_result !== er.last) begin
                  $error("last_result: expected %0d actual %0d", er.last,
                         rsp_last_result);
                  err_count++;
               end
            end
         end
         if (hold_off)
            rsp_ready <= 1'b0;
         else if (cycle_count[11])
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_node(input logic [31:0] x, input logic [31:0] y, input bit last);
      node_item_type it;
      it.x    = x;
      it.y    = y;
      it.last = last;
      node_queue.push_back(it);
   endtask

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 5) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
   endfunction

   // wait for the block to drain, then write query x
   task automatic set_query(input logic [31:0] q);
      wait (node_queue.size() == 0);
      @(posedge clock);
      while (req_valid || result_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= q;
      pquery = $signed(q);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_set();
      int          n;
      logic [31:0] xs[16];
      n = $urandom_range(2, 5);
      if ($urandom_range(0, 11) == 0) n = 1;
      if ($urandom_range(0, 14) == 0) n = $urandom_range(8, 10);
      for (int i = 0; i < n; i++) begin
         xs[i] = rand_coord();
         if (i > 0 && $urandom_range(0, 9) == 0) xs[i] = xs[$urandom_range(0, i - 1)];
         add_node(xs[i], rand_coord(), i == n - 1);
      end
   endtask

   initial begin
      int items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: three nodes, extremes, duplicate x, single node, overflow of store
      set_query(32'h0001_8000);
      add_node(32'h0000_0000, 32'h0000_0000, 0);
      add_node(32'h0002_0000, 32'h0004_0000, 0);
      add_node(32'h0003_0000, 32'hFFFF_0000, 1);
      add_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      add_node(32'h8000_0000, 32'h8000_0000, 1);
      add_node(32'h0001_0000, 32'h0001_0000, 0);
      add_node(32'h0001_0000, 32'h0002_0000, 0);
      add_node(32'h0005_0000, 32'h0002_0000, 1);
      add_node(32'h1234_5678, 32'h0001_0000, 1);
      for (int i = 0; i < 10; i++)
         add_node(i * 32'h0001_0000, 32'h0001_0000 * (i + 1), i == 9);
      set_query(32'h7FFF_FFFF);
      add_node(32'h0000_0000, 32'h7FFF_FFFF, 0);
      add_node(32'h0000_0001, 32'h8000_0000, 1);
      set_query(32'h8000_0000);
      add_node(32'h7FFF_FFFF, 32'h0001_0000, 0);
      add_node(32'h8000_0000, 32'hFFFF_FFFF, 1);
      // random phases with a range of query points
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_query(32'h0000_0000);
            1: set_query(32'h7FFF_FFFF);
            2: set_query(32'h8000_0000);
            default: set_query(rand_coord());
         endcase
         items = node_queue.size();
         while (node_queue.size() - items < 41) random_set();
      end
      wait (node_queue.size() == 0);
      @(posedge clock);
      while (req_valid || result_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (err_count == 0 && result_queue.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
